[rtl/core/ltu8_pkg.sv]
`default_nettype none

package ltu8_pkg;

  typedef logic [7:0] byte_t;

  localparam int unsigned MaxResults = 6;
  localparam int unsigned CntW       = 3;
  localparam int unsigned PaddrW     = 3;
  localparam int unsigned ApbDataW   = 32;

  localparam logic [PaddrW-1:0] RegEncodingAddr = 3'd0;

  typedef enum logic [2:0] {
    SRC_UTF8      = 3'd0,
    SRC_UTF8_BOM  = 3'd1,
    SRC_UTF16_LE  = 3'd2,
    SRC_UTF16_BE  = 3'd3,
    SRC_CP1252    = 3'd4,
    SRC_ISO8859_1 = 3'd5
  } encoding_e;

  // one code point as 1..4 UTF-8 bytes, bytes[0] goes out first
  typedef struct packed {
    logic [2:0]       len;
    logic [3:0][7:0]  bytes;
  } utf8_seq_t;

  function automatic utf8_seq_t cp_to_utf8(input logic [20:0] cp);
    utf8_seq_t s;
    s.bytes = '0;
    if (cp < 21'h80) begin
      s.len      = 3'd1;
      s.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      s.len      = 3'd2;
      s.bytes[0] = {3'b110, cp[10:6]};
      s.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      s.len      = 3'd3;
      s.bytes[0] = {4'b1110, cp[15:12]};
      s.bytes[1] = {2'b10, cp[11:6]};
      s.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      s.len      = 3'd4;
      s.bytes[0] = {5'b11110, cp[20:18]};
      s.bytes[1] = {2'b10, cp[17:12]};
      s.bytes[2] = {2'b10, cp[11:6]};
      s.bytes[3] = {2'b10, cp[5:0]};
    end
    return s;
  endfunction

  // Windows-1252 code points for bytes 0x80..0x9F
  function automatic logic [15:0] win1252_map(input logic [4:0] idx);
    logic [15:0] cp;
    unique case (idx)
      5'd0:  cp = 16'h20AC;
      5'd1:  cp = 16'h0081;
      5'd2:  cp = 16'h201A;
      5'd3:  cp = 16'h0192;
      5'd4:  cp = 16'h201E;
      5'd5:  cp = 16'h2026;
      5'd6:  cp = 16'h2020;
      5'd7:  cp = 16'h2021;
      5'd8:  cp = 16'h02C6;
      5'd9:  cp = 16'h2030;
      5'd10: cp = 16'h0160;
      5'd11: cp = 16'h2039;
      5'd12: cp = 16'h0152;
      5'd13: cp = 16'h008D;
      5'd14: cp = 16'h017D;
      5'd15: cp = 16'h008F;
      5'd16: cp = 16'h0090;
      5'd17: cp = 16'h2018;
      5'd18: cp = 16'h2019;
      5'd19: cp = 16'h201C;
      5'd20: cp = 16'h201D;
      5'd21: cp = 16'h2022;
      5'd22: cp = 16'h2013;
      5'd23: cp = 16'h2014;
      5'd24: cp = 16'h02DC;
      5'd25: cp = 16'h2122;
      5'd26: cp = 16'h0161;
      5'd27: cp = 16'h203A;
      5'd28: cp = 16'h0153;
      5'd29: cp = 16'h009D;
      5'd30: cp = 16'h017E;
      5'd31: cp = 16'h0178;
      default: cp = 16'h0000;
    endcase
    return cp;
  endfunction

endpackage

`default_nettype wire

[rtl/core/ltu8_in_if.sv]
`default_nettype none

interface ltu8_in_if;
  logic                 valid;
  logic                 ready;
  ltu8_pkg::byte_t      in_byte;
  logic                 first_of_file;
  logic                 last_of_file;

  modport source (output valid, output in_byte, output first_of_file,
                  output last_of_file, input ready);
  modport sink   (input valid, input in_byte, input first_of_file,
                  input last_of_file, output ready);
endinterface

`default_nettype wire

[rtl/core/ltu8_out_if.sv]
`default_nettype none

interface ltu8_out_if;
  logic                 valid;
  logic                 ready;
  ltu8_pkg::byte_t      out_byte;
  logic                 out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

[rtl/core/legacy_text_to_utf8_transcoder.sv]
`default_nettype none

// channel | dir | payload                              | handshake
// in_i    | in  | in_byte[8], first_of_file, last_of_file | valid/ready
// out_o   | out | out_byte[8], out_last                | valid/ready
// apb     | in  | encoding[2:0] at byte address 0      | psel/penable, pready=1
//
// An input byte is registered, decoded combinationally and its 0..6 UTF-8 bytes
// land in a result buffer that drains one byte per cycle while out_o is ready.
// The one-byte output port sets the pace; a new item loads into the buffer in
// the cycle the previous last byte leaves.
// Reset clears the encoding register and all per-file state; no clearing pass.
// A stalled output holds the buffer and the input register backs up behind it.

module legacy_text_to_utf8_transcoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  ltu8_in_if.sink                            in_i,
  ltu8_out_if.source                         out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ltu8_pkg::PaddrW-1:0]   paddr,
  input  wire logic [ltu8_pkg::ApbDataW-1:0] pwdata,
  output logic      [ltu8_pkg::ApbDataW-1:0] prdata,
  output logic                               pready
);

  // configuration
  logic [2:0] enc_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q <= ltu8_pkg::SRC_UTF8;
    end else if (psel && penable && pwrite && paddr == ltu8_pkg::RegEncodingAddr) begin
      enc_q <= pwdata[2:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ltu8_pkg::RegEncodingAddr) begin
      prdata[2:0] = enc_q;
    end
  end

  // input register
  logic                 iv_q;
  ltu8_pkg::byte_t      ib_q;
  logic                 ifirst_q;
  logic                 ilast_q;
  logic                 consume;

  assign in_i.ready = !iv_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (in_i.ready) begin
      iv_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ib_q     <= in_i.in_byte;
      ifirst_q <= in_i.first_of_file;
      ilast_q  <= in_i.last_of_file;
    end
  end

  // per-file state
  logic [1:0][7:0] hold_q, hold_d;
  logic [1:0]      sc_q, sc_d;
  logic [7:0]      hu_q, hu_d;
  logic            hv_q, hv_d;
  logic [9:0]      ph_q, ph_d;
  logic            pv_q, pv_d;

  // decode
  logic [1:0][7:0] hold;
  logic [1:0]      sc;
  logic [7:0]      hu;
  logic            hv;
  logic [9:0]      ph;
  logic            pv;
  logic [15:0]     c16;
  logic            is_high, is_low;
  logic [2:0][7:0] raw;
  logic [1:0]      raw_len;
  logic            use_cp;
  logic            a_v, b_v;
  logic [20:0]     a_cp, b_cp;
  ltu8_pkg::utf8_seq_t seq_a, seq_b;
  logic [2:0]      len_a, len_b;
  logic [ltu8_pkg::MaxResults-1:0][7:0] res;
  logic [ltu8_pkg::CntW-1:0] res_len;

  always_comb begin
    hold = ifirst_q ? '0 : hold_q;
    sc   = ifirst_q ? 2'd0 : sc_q;
    hu   = ifirst_q ? 8'd0 : hu_q;
    hv   = ifirst_q ? 1'b0 : hv_q;
    ph   = ifirst_q ? 10'd0 : ph_q;
    pv   = ifirst_q ? 1'b0 : pv_q;

    hold_d = hold;
    sc_d   = sc;
    hu_d   = hu;
    hv_d   = hv;
    ph_d   = ph;
    pv_d   = pv;

    raw     = '0;
    raw_len = 2'd0;
    use_cp  = 1'b0;
    a_v     = 1'b0;
    a_cp    = '0;
    b_v     = 1'b0;
    b_cp    = '0;

    c16     = (enc_q == ltu8_pkg::SRC_UTF16_LE) ? {ib_q, hu} : {hu, ib_q};
    is_high = (c16[15:10] == 6'b110110);
    is_low  = (c16[15:10] == 6'b110111);

    case (enc_q) inside
      ltu8_pkg::SRC_UTF8_BOM: begin
        if (sc[1] == 1'b0) begin
          if (ilast_q) begin
            if (sc[0]) begin
              raw[0]  = hold[0];
              raw[1]  = ib_q;
              raw_len = 2'd2;
            end else begin
              raw[0]  = ib_q;
              raw_len = 2'd1;
            end
          end else begin
            hold_d[sc[0]] = ib_q;
            sc_d          = sc + 2'd1;
          end
        end else if (sc == 2'd2) begin
          // drop the mark EF BB BF, else release the held bytes
          if (!(hold[0] == 8'hEF && hold[1] == 8'hBB && ib_q == 8'hBF)) begin
            raw[0]  = hold[0];
            raw[1]  = hold[1];
            raw[2]  = ib_q;
            raw_len = 2'd3;
          end
          sc_d = 2'd3;
        end else begin
          raw[0]  = ib_q;
          raw_len = 2'd1;
        end
      end
      ltu8_pkg::SRC_UTF16_LE, ltu8_pkg::SRC_UTF16_BE: begin
        use_cp = 1'b1;
        if (!hv) begin
          if (!ilast_q) begin
            hu_d = ib_q;
            hv_d = 1'b1;
          end
        end else begin
          hv_d = 1'b0;
          hu_d = 8'd0;
          sc_d = 2'd3;
          if (!(sc != 2'd3 && c16 == 16'hFEFF)) begin
            if (pv && is_low) begin
              a_v  = 1'b1;
              a_cp = 21'h10000 + {1'b0, ph, c16[9:0]};
              pv_d = 1'b0;
              ph_d = 10'd0;
            end else begin
              if (pv) begin
                // lone high surrogate goes out as is
                a_v  = 1'b1;
                a_cp = {5'd0, 6'b110110, ph};
                pv_d = 1'b0;
                ph_d = 10'd0;
              end
              if (is_high) begin
                pv_d = 1'b1;
                ph_d = c16[9:0];
              end else if (pv) begin
                b_v  = 1'b1;
                b_cp = {5'd0, c16};
              end else begin
                a_v  = 1'b1;
                a_cp = {5'd0, c16};
              end
            end
          end
        end
        if (ilast_q && pv_d) begin
          b_v  = 1'b1;
          b_cp = {5'd0, 6'b110110, ph_d};
        end
      end
      ltu8_pkg::SRC_CP1252, ltu8_pkg::SRC_ISO8859_1: begin
        use_cp = 1'b1;
        a_v    = 1'b1;
        if (enc_q == ltu8_pkg::SRC_CP1252 && ib_q[7:5] == 3'b100) begin
          a_cp = {5'd0, ltu8_pkg::win1252_map(ib_q[4:0])};
        end else begin
          a_cp = {13'd0, ib_q};
        end
      end
      default: begin
        raw[0]  = ib_q;
        raw_len = 2'd1;
      end
    endcase

    if (ilast_q) begin
      hold_d = '0;
      sc_d   = 2'd0;
      hu_d   = 8'd0;
      hv_d   = 1'b0;
      ph_d   = 10'd0;
      pv_d   = 1'b0;
    end
  end

  assign seq_a = ltu8_pkg::cp_to_utf8(a_cp);
  assign seq_b = ltu8_pkg::cp_to_utf8(b_cp);
  assign len_a = a_v ? seq_a.len : 3'd0;
  assign len_b = b_v ? seq_b.len : 3'd0;

  // pack the two code points back to back
  always_comb begin
    logic [2:0] j;
    j   = '0;
    res = '0;
    for (int i = 0; i < ltu8_pkg::MaxResults; i++) begin
      if (use_cp) begin
        if (3'(i) < len_a) begin
          res[i] = seq_a.bytes[i[1:0]];
        end else begin
          j = 3'(i) - len_a;
          if (j < len_b) begin
            res[i] = seq_b.bytes[j[1:0]];
          end
        end
      end else if (i < 3) begin
        res[i] = raw[i];
      end
    end
    res_len = use_cp ? (len_a + len_b) : {1'b0, raw_len};
  end

  // result buffer
  logic [ltu8_pkg::MaxResults-1:0][7:0] obuf_q;
  logic [ltu8_pkg::CntW-1:0]            cnt_q;
  logic [ltu8_pkg::CntW-1:0]            idx_q;
  logic                                 take_last;
  logic                                 obuf_open;

  assign out_o.valid    = (cnt_q != '0);
  assign out_o.out_byte = obuf_q[idx_q];
  assign out_o.out_last = (idx_q == cnt_q - 3'd1);
  assign take_last      = out_o.valid && out_o.ready && out_o.out_last;
  assign obuf_open      = (cnt_q == '0) || take_last;
  assign consume        = iv_q && obuf_open;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      idx_q  <= '0;
      hold_q <= '0;
      sc_q   <= 2'd0;
      hu_q   <= 8'd0;
      hv_q   <= 1'b0;
      ph_q   <= 10'd0;
      pv_q   <= 1'b0;
    end else begin
      if (consume) begin
        cnt_q  <= res_len;
        idx_q  <= '0;
        hold_q <= hold_d;
        sc_q   <= sc_d;
        hu_q   <= hu_d;
        hv_q   <= hv_d;
        ph_q   <= ph_d;
        pv_q   <= pv_d;
      end else if (take_last) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else if (out_o.valid && out_o.ready) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      obuf_q <= res;
    end
  end

  // checks
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> idx_q < cnt_q)
    else $error("result index past item length");

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> iv_q && !obuf_open)
    else $error("input stalled with nothing held");

  a_result_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && res_len != '0 |=> out_o.valid && idx_q == '0)
    else $error("decoded item did not reach the output");

  a_max_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume |-> res_len <= 3'(ltu8_pkg::MaxResults))
    else $error("item longer than the result buffer");

endmodule

`default_nettype wire
